// ----- hdl/vct_pkg.sv -----
`timescale 1ns / 1ps
// Package for the value count table: widths, codes and controller types.
// Used by the interfaces, the controller, the datapath and the top level.
package vct_pkg;

  localparam int unsigned VCT_DEPTH   = 64;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned STATUS_W    = 2;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_READ,
    S_MULT,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic capture;
    logic match;
    logic read;
    logic mult;
    logic update;
  } cmd_t;

endpackage

// ----- hdl/vct_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the value count table.
// Depends on vct_pkg for the payload widths.
interface vct_req_if import vct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] item_value;

  modport source (output valid, output func, output item_value, input ready);
  modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface vct_rsp_if import vct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  value_count;
  logic [STATUS_W-1:0] status;
  logic [SUM_W-1:0]    weighted_sum;

  modport source (output valid, output value_count, output status, output weighted_sum,
                  input ready);
  modport sink   (input valid, input value_count, input status, input weighted_sum,
                  output ready);
endinterface

// ----- hdl/vct_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the value count table: sequences match, read, multiply, update.
// Depends on vct_pkg for the state and command types.
module vct_ctrl import vct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_valid_i) state_d = S_MATCH;
      S_MATCH:  state_d = S_READ;
      S_READ:   state_d = S_MULT;
      S_MULT:   state_d = S_UPDATE;
      S_UPDATE: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      S_MATCH:  cmd_o.match = 1'b1;
      S_READ:   cmd_o.read  = 1'b1;
      S_MULT:   cmd_o.mult  = 1'b1;
      S_UPDATE: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// ----- hdl/vct_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the value count table: value CAM, count memory, sum and result.
// Depends on vct_pkg; driven by commands from vct_ctrl.
module vct_dp import vct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = VCT_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                func_i,
  input  logic [VALUE_W-1:0]  item_value_i,
  output logic [COUNT_W-1:0]  value_count_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SUM_W-1:0]    weighted_sum_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic                   func_q;
  logic [VALUE_W-1:0]     val_q;
  logic [TABLE_DEPTH-1:0] used_q;
  logic [VALUE_W-1:0]     vals_q [TABLE_DEPTH];
  logic [COUNT_W-1:0]     cnt_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0]     cnt_rd_q;

  logic                   hit_c, free_c, hit_q, free_q;
  logic [IDX_W-1:0]       hit_idx_c, free_idx_c, hit_idx_q, free_idx_q;

  logic [SUM_W-1:0]       wide;
  logic [2*VALUE_W+1:0]   prod_full;
  logic [SUM_W-1:0]       prod_q;
  logic [SUM_W-1:0]       sum_q, sum_d;

  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr;
  logic [COUNT_W-1:0]     cnt_wdata;
  logic [COUNT_W-1:0]     cnt_inc;
  logic                   set_used, clr_used;
  logic [COUNT_W-1:0]     res_count;
  status_e                res_status;
  logic [COUNT_W-1:0]     rsp_count_q;
  status_e                rsp_status_q;

  assign wide    = {{(SUM_W-VALUE_W){val_q[VALUE_W-1]}}, val_q};
  assign cnt_inc = cnt_rd_q + COUNT_W'(1);

  // lowest matching entry and lowest free entry
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (used_q[i] && vals_q[i] == val_q) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!used_q[i]) begin
        free_c     = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  // signed value times unsigned count, kept modulo 2^64
  assign prod_full = $signed({val_q[VALUE_W-1], val_q}) * $signed({1'b0, cnt_rd_q});

  always_comb begin
    sum_d      = sum_q;
    cnt_we     = 1'b0;
    cnt_waddr  = hit_idx_q;
    cnt_wdata  = cnt_inc;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    res_count  = '0;
    res_status = ST_DONE;
    if (func_q == FUNC_ADD) begin
      if (hit_q) begin
        if (cnt_rd_q != '1) begin
          cnt_we    = 1'b1;
          sum_d     = sum_q + wide;
          res_count = cnt_inc;
        end else begin
          res_count = cnt_rd_q;
        end
      end else if (free_q) begin
        cnt_we    = 1'b1;
        cnt_waddr = free_idx_q;
        cnt_wdata = COUNT_W'(1);
        set_used  = 1'b1;
        sum_d     = sum_q + wide;
        res_count = COUNT_W'(1);
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      if (hit_q) begin
        sum_d    = sum_q - prod_q;
        clr_used = 1'b1;
      end else begin
        res_status = ST_MISS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      val_q  <= item_value_i;
    end
    if (cmd_i.match) begin
      hit_q      <= hit_c;
      hit_idx_q  <= hit_idx_c;
      free_q     <= free_c;
      free_idx_q <= free_idx_c;
    end
    if (cmd_i.read) cnt_rd_q <= cnt_mem[hit_idx_q];
    if (cmd_i.mult) prod_q   <= prod_full[SUM_W-1:0];
    if (cmd_i.update) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (set_used) vals_q[free_idx_q] <= val_q;
      rsp_count_q  <= res_count;
      rsp_status_q <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.update) begin
      sum_q <= sum_d;
      if (set_used) used_q[free_idx_q] <= 1'b1;
      if (clr_used) used_q[hit_idx_q]  <= 1'b0;
    end
  end

  assign value_count_o  = rsp_count_q;
  assign status_o       = rsp_status_q;
  assign weighted_sum_o = sum_q;

endmodule

// ----- hdl/value_count_table_unit.sv -----
`timescale 1ns / 1ps
// Top level of the value count table: controller plus datapath.
// Depends on vct_pkg, vct_if, vct_ctrl and vct_dp.
//
// Usage:
//   req_i carries func (0 add one occurrence, 1 remove the value) and a
//   signed 32-bit item_value. rsp_o returns one item per request: the
//   value's count after the request, a status (done, table full, not
//   found) and the wrapping 64-bit sum of value times count.
//   An accepted request is captured, then the controller walks match,
//   count read, multiply and update in turn over a single count memory
//   port, registering the response; one request is handled at a time and
//   req_i.ready is high only while the controller idles.
//   A finished response waits in the output register while the next
//   request is taken and matched; the update step stalls there until the
//   receiver has taken the previous response.
//   Reset clears every entry's used bit and the sum at once; the block
//   takes requests in the first cycle after reset.
module value_count_table_unit import vct_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = VCT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vct_req_if.sink    req_i,
  vct_rsp_if.source  rsp_o
);

  cmd_t cmd;

  vct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  vct_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (req_i.func),
    .item_value_i   (req_i.item_value),
    .value_count_o  (rsp_o.value_count),
    .status_o       (rsp_o.status),
    .weighted_sum_o (rsp_o.weighted_sum)
  );

endmodule

// ----- hdl/vct_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for value_count_table_unit, attached by bind.
// Depends on vct_pkg for widths and status codes.
module vct_checker import vct_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [COUNT_W-1:0]  value_count_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [SUM_W-1:0]    weighted_sum_i
);

  // a stalled response holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(value_count_i)
      && $stable(status_i) && $stable(weighted_sum_i))
    else $error("stalled response changed");

  // one request at a time: no new request right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in flight");

  // a response valid never rises while its request is in the match, read or multiply step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !$rose(rsp_valid_i) ##1 !$rose(rsp_valid_i)
      ##1 !$rose(rsp_valid_i))
    else $error("response too early");

  // failed requests report no count, and status is a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_DONE |-> value_count_i == '0
      && (status_i == ST_FULL || status_i == ST_MISS))
    else $error("bad status or count on failed request");

endmodule

bind value_count_table_unit vct_checker u_vct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .value_count_i  (rsp_o.value_count),
  .status_i       (rsp_o.status),
  .weighted_sum_i (rsp_o.weighted_sum)
);
